### sv/bsrra_pkg.sv
// ----------------------------------------------------------------------------
// bsrra_pkg
// Shared types and constants for the busy-server round-robin assigner.
// ----------------------------------------------------------------------------
`default_nettype none

package bsrra_pkg;

  localparam int MAX_SERVERS_DEF = 16;
  localparam int TIME_IN_W       = 31;
  localparam int TIME_W          = 32;
  localparam int COUNT_W         = 32;
  localparam int SERVER_W        = 4;
  localparam int MASK_W          = 16;
  localparam int CFG_W           = 5;

  localparam logic [CFG_W-1:0]   SERVER_COUNT_RST = CFG_W'(16);
  localparam logic [COUNT_W-1:0] COUNT_SAT        = '1;

  typedef struct packed {
    logic [TIME_IN_W-1:0] arrival_time;
    logic [TIME_IN_W-1:0] duration;
  } call_t;

  typedef struct packed {
    logic                accepted;
    logic [SERVER_W-1:0] server;
    logic [MASK_W-1:0]   busiest_mask;
    logic [COUNT_W-1:0]  busiest_count;
  } result_t;

  // Flags from the shared compare unit
  typedef struct packed {
    logic expired;  // end time at or before arrival
    logic gt;       // candidate count above running best
    logic eq;       // candidate count equal to running best
  } cmp_flags_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

### sv/busy_server_round_robin_assigner.sv
// ----------------------------------------------------------------------------
// busy_server_round_robin_assigner
// Assigns calls to servers round robin, with per-server busy timers.
// ----------------------------------------------------------------------------
// One call is taken when start is high and busy is low. The block then walks
// the server table one entry per cycle through a single compare unit: each
// step frees the server if its end time is at or before the arrival time,
// notes the first free server at or after the start index (and the first one
// before it, for the wrap), and ranks the server's served count. The commit
// state ST_DONE then commits the chosen server and ranks its new count. busy
// stays high from the accepting edge through the walk and the commit, and
// drops before the next call is taken, so a new call is not taken until the
// current one is through; the table walk over the two server memories sets
// the call rate. The result item appears on result for exactly one cycle,
// marked by done, in the cycle where busy drops. The receiver cannot hold
// it off and must take it in that cycle. server_count may be written at any
// time the block is idle; it takes effect on the next call. No clearing pass
// runs after reset: served counts carry a valid bit per server, and end
// times matter only for busy servers.
// ----------------------------------------------------------------------------
`default_nettype none

module busy_server_round_robin_assigner #(
  parameter int MAX_SERVERS = bsrra_pkg::MAX_SERVERS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  bsrra_pkg::call_t              call,
  input  logic                          cfg_we,
  input  logic [bsrra_pkg::CFG_W-1:0]   cfg_wdata,
  output logic                          done,
  output bsrra_pkg::result_t            result
);
  import bsrra_pkg::*;

  localparam int IDX_W = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
  localparam int K_W   = $clog2(MAX_SERVERS + 1);

  // Configuration and round-robin pointer
  logic [CFG_W-1:0] server_count;
  logic [IDX_W-1:0] call_mod;

  // Per-server state
  logic [MAX_SERVERS-1:0] server_busy;
  logic [MAX_SERVERS-1:0] cnt_valid;
  logic [TIME_W-1:0]      busy_until   [MAX_SERVERS];
  logic [COUNT_W-1:0]     served_count [MAX_SERVERS];

  // Per-call working registers
  state_t               state, state_next;
  logic [K_W-1:0]       k_r;
  logic [K_W-1:0]       start_r;
  logic [TIME_W-1:0]    arrival_r;
  logic [TIME_W-1:0]    end_r;
  logic [K_W-1:0]       ia;
  logic                 proc_vld;
  logic [IDX_W-1:0]     proc_idx;
  logic [TIME_W-1:0]    until_q;
  logic [COUNT_W-1:0]   cnt_q;
  logic                 cvld_q;
  logic                 hi_found, lo_found;
  logic [IDX_W-1:0]     hi_idx, lo_idx;
  logic [COUNT_W-1:0]   hi_cnt, lo_cnt;
  logic [COUNT_W-1:0]   best;
  logic [MAX_SERVERS-1:0] best_mask;

  // Combinational
  logic                   accept;
  logic                   issue;
  logic [K_W-1:0]         k_cfg;
  logic [K_W-1:0]         start_cfg;
  logic [K_W-1:0]         start_inc;
  logic [COUNT_W-1:0]     c_eff;
  logic                   slot_free;
  logic                   slot_in_use;
  logic [MAX_SERVERS-1:0] slot_bit;
  logic                   found;
  logic [IDX_W-1:0]       pick;
  logic [COUNT_W-1:0]     pick_cnt;
  logic [COUNT_W-1:0]     new_cnt;
  logic [MAX_SERVERS-1:0] pick_bit;
  logic [COUNT_W-1:0]     cmp_lhs;
  cmp_flags_t             flags;
  logic [COUNT_W-1:0]     top_count_fin;
  logic [MAX_SERVERS-1:0] top_mask_fin;

  assign accept = start && !busy;
  assign busy   = (state != ST_IDLE);

  // Clamp the register to 1..MAX_SERVERS
  always_comb begin
    if (server_count == '0) begin
      k_cfg = K_W'(1);
    end else if (32'(server_count) > 32'(MAX_SERVERS)) begin
      k_cfg = K_W'(MAX_SERVERS);
    end else begin
      k_cfg = K_W'(server_count);
    end
    start_cfg = (K_W'(call_mod) < k_cfg) ? K_W'(call_mod) : '0;
  end

  assign start_inc = start_r + K_W'(1);

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    issue      = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // Issue one table read a cycle; the last read is processed when the
        // issue counter has run out
        issue = (ia != K_W'(MAX_SERVERS));
        if (!issue) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Configuration register and round-robin pointer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      server_count <= SERVER_COUNT_RST;
      call_mod     <= '0;
    end else begin
      if (cfg_we) begin
        server_count <= cfg_wdata;
      end
      // Advance the pointer for every call, taken or dropped
      if (state == ST_DONE) begin
        call_mod <= (start_inc >= k_r) ? '0 : IDX_W'(start_inc);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Server memories: one read per issued table step, one write at commit
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (issue) begin
      until_q <= busy_until[ia[IDX_W-1:0]];
      cnt_q   <= served_count[ia[IDX_W-1:0]];
    end
    if ((state == ST_DONE) && found) begin
      busy_until[pick]   <= end_r;
      served_count[pick] <= new_cnt;
    end
  end

  // Busy and count-valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      server_busy <= '0;
      cnt_valid   <= '0;
      cvld_q      <= 1'b0;
    end else begin
      if (issue) begin
        cvld_q <= cnt_valid[ia[IDX_W-1:0]];
      end
      if (proc_vld && flags.expired) begin
        server_busy[proc_idx] <= 1'b0;
      end else if ((state == ST_DONE) && found) begin
        server_busy[pick] <= 1'b1;
        cnt_valid[pick]   <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Scan step
  // ---------------------------------------------------------------------------
  assign c_eff       = cvld_q ? cnt_q : '0;
  assign slot_free   = !server_busy[proc_idx] || flags.expired;
  assign slot_in_use = (K_W'(proc_idx) < k_r);
  assign slot_bit    = MAX_SERVERS'(1) << proc_idx;

  // At commit the compare unit ranks the chosen server's new count
  assign cmp_lhs = (state == ST_DONE) ? new_cnt : c_eff;

  bsrra_cmp u_cmp (
    .end_time (until_q),
    .arrival  (arrival_r),
    .count    (cmp_lhs),
    .best     (best),
    .flags    (flags)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      proc_vld <= 1'b0;
      hi_found <= 1'b0;
      lo_found <= 1'b0;
      ia       <= '0;
    end else begin
      proc_vld <= issue;
      if (accept) begin
        hi_found <= 1'b0;
        lo_found <= 1'b0;
        ia       <= '0;
      end else begin
        if (issue) begin
          ia <= ia + K_W'(1);
        end
        if (proc_vld && slot_in_use && slot_free) begin
          if ((K_W'(proc_idx) >= start_r) && !hi_found) begin
            hi_found <= 1'b1;
          end
          if ((K_W'(proc_idx) < start_r) && !lo_found) begin
            lo_found <= 1'b1;
          end
        end
      end
    end
  end

  // Latch call data and track candidates and the running maximum
  always_ff @(posedge clk) begin
    proc_idx <= ia[IDX_W-1:0];
    if (accept) begin
      k_r       <= k_cfg;
      start_r   <= start_cfg;
      arrival_r <= TIME_W'(call.arrival_time);
      end_r     <= TIME_W'(call.arrival_time) + TIME_W'(call.duration);
      best      <= '0;
      best_mask <= '0;
    end else if (proc_vld && slot_in_use) begin
      if (slot_free && (K_W'(proc_idx) >= start_r) && !hi_found) begin
        hi_idx <= proc_idx;
        hi_cnt <= c_eff;
      end
      if (slot_free && (K_W'(proc_idx) < start_r) && !lo_found) begin
        lo_idx <= proc_idx;
        lo_cnt <= c_eff;
      end
      if (flags.gt) begin
        best      <= c_eff;
        best_mask <= slot_bit;
      end else if (flags.eq) begin
        best_mask <= best_mask | slot_bit;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Commit: choose, bump the count, fold it into the ranking
  // ---------------------------------------------------------------------------
  always_comb begin
    found    = hi_found || lo_found;
    pick     = hi_found ? hi_idx : lo_idx;
    pick_cnt = hi_found ? hi_cnt : lo_cnt;
    new_cnt  = (pick_cnt == COUNT_SAT) ? pick_cnt : pick_cnt + COUNT_W'(1);
    pick_bit = MAX_SERVERS'(1) << pick;
    top_count_fin = best;
    top_mask_fin  = best_mask;
    if (found && flags.gt) begin
      top_count_fin = new_cnt;
      top_mask_fin  = pick_bit;
    end else if (found && flags.eq) begin
      top_mask_fin  = best_mask | pick_bit;
    end
  end

  // Result register: shown for one cycle, no back-pressure
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == ST_DONE);
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE) begin
      result.accepted      <= found;
      result.server        <= found ? SERVER_W'(pick) : '0;
      result.busiest_mask  <= MASK_W'(top_mask_fin);
      result.busiest_count <= top_count_fin;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_done_after_commit: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == ST_DONE))
    else $error("result strobe without a commit cycle");

  a_proc_in_scan: assert property (@(posedge clk) disable iff (rst)
    proc_vld |-> (state == ST_SCAN))
    else $error("table step processed outside the scan");

  a_busy_has_count: assert property (@(posedge clk) disable iff (rst)
    (server_busy & ~cnt_valid) == '0)
    else $error("busy server was never written");

  a_accept_starts_scan: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_SCAN) && (ia == '0))
    else $error("accepted call did not start a scan");

  a_one_scan_length: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE) |-> $past(state == ST_SCAN) && (ia == K_W'(MAX_SERVERS)))
    else $error("commit before the table walk finished");

endmodule

`default_nettype wire

### sv/bsrra_cmp.sv
// ----------------------------------------------------------------------------
// bsrra_cmp
// Shared compare unit: timer expiry and served-count ranking.
// ----------------------------------------------------------------------------
`default_nettype none

module bsrra_cmp (
  input  logic [bsrra_pkg::TIME_W-1:0]  end_time,
  input  logic [bsrra_pkg::TIME_W-1:0]  arrival,
  input  logic [bsrra_pkg::COUNT_W-1:0] count,
  input  logic [bsrra_pkg::COUNT_W-1:0] best,
  output bsrra_pkg::cmp_flags_t         flags
);
  import bsrra_pkg::*;

  always_comb begin
    flags.expired = (end_time <= arrival);
    flags.gt      = (count > best);
    flags.eq      = (count == best);
  end

endmodule

`default_nettype wire
